// ===== sv/pwm_dimmer_button_adjust_core_assert.svh =====
// Assertion helpers for the dimmer RTL.
// Each macro samples on the rising edge of clk and stays quiet while rst_n is low.
`ifndef PWM_DIMMER_BUTTON_ADJUST_CORE_ASSERT_SVH
`define PWM_DIMMER_BUTTON_ADJUST_CORE_ASSERT_SVH

// Same-cycle implication
`define PDBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PDBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pdba_pkg.sv =====
package pdba_pkg;

    // Phase wraps here; duty saturates here
    localparam logic [6:0] PhaseWrap = 7'd100;
    localparam logic [6:0] DutyMax   = 7'd100;
    localparam logic [6:0] DutyReset = 7'd50;

    // Segment patterns for the fixed displays
    localparam logic [7:0] SegZero  = 8'h3F;
    localparam logic [7:0] SegFull  = 8'hBF;
    localparam logic [7:0] SegReset = 8'hFF;
    localparam logic [7:0] PatTensReset  = 8'h6D;
    localparam logic [7:0] PatUnitsReset = 8'h3F;

    // Digit enables: bit 0 tens digit, bit 1 units digit
    localparam logic [1:0] EnTens  = 2'b01;
    localparam logic [1:0] EnUnits = 2'b10;
    localparam logic [1:0] EnBoth  = 2'b11;

    localparam logic [9:0] LevelReset = 10'h01F;
    localparam logic [9:0] BarReset   = 10'h3FF;

    // Register defaults
    localparam logic [7:0] HoldDelayReset   = 8'd100;
    localparam logic [7:0] RepeatIvalReset  = 8'd10;
    localparam logic [7:0] FlowIvalReset    = 8'd10;
    localparam logic [7:0] ResyncIvalReset  = 8'd100;

    typedef enum logic [1:0] {
        CFG_HOLD_DELAY      = 2'd0,
        CFG_REPEAT_INTERVAL = 2'd1,
        CFG_FLOW_INTERVAL   = 2'd2,
        CFG_RESYNC_INTERVAL = 2'd3
    } cfg_reg_t;

    // Slow-tick strobe and button activity handed to the display
    typedef struct packed {
        logic slow;
        logic any;
    } tick_t;

    // Tens digit of a duty value (multiply by reciprocal of ten), not clipped
    function automatic logic [3:0] tens_of(input logic [6:0] d);
        logic [14:0] prod;
        prod = {8'd0, d} * 15'd205;
        return prod[14:11];
    endfunction

    // Tens digit clipped to ten
    function automatic logic [3:0] tens_clip(input logic [6:0] d);
        logic [3:0] t;
        t = tens_of(d);
        return (t > 4'd10) ? 4'd10 : t;
    endfunction

    // Units digit: value minus ten times the tens digit
    function automatic logic [3:0] units_of(input logic [6:0] d);
        logic [3:0] t;
        logic [6:0] tx;
        logic [6:0] r;
        t  = tens_of(d);
        tx = {t, 3'b000} - {2'b00, t, 1'b0} + {2'b00, t, 1'b0} + {2'b00, t, 1'b0};
        r  = d - tx;
        return r[3:0];
    endfunction

    // Seven-segment glyphs; ten has no glyph and shows blank
    function automatic logic [7:0] glyph(input logic [3:0] n);
        logic [7:0] g;
        unique case (n)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // Thermometer of duty/10, capped at ten bars
    function automatic logic [9:0] thermometer(input logic [6:0] d);
        logic [10:0] one_hot;
        logic [10:0] m;
        one_hot = 11'd1 << tens_clip(d);
        m = one_hot - 11'd1;
        return m[9:0];
    endfunction

endpackage

// ===== sv/pdba_display.sv =====
module pdba_display
    import pdba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tick_t       tick,
    input  logic [6:0]  duty,
    output logic [7:0]  seg_next,
    output logic [1:0]  enables_next
);

    logic       select_reg;
    logic       select_next;
    logic [7:0] pat_tens_reg;
    logic [7:0] pat_tens_next;
    logic [7:0] pat_units_reg;
    logic [7:0] pat_units_next;
    logic [7:0] seg_reg;
    logic [1:0] enables_reg;

    // Refresh patterns while a button is held, then pick what to drive
    always_comb
    begin
        pat_tens_next  = pat_tens_reg;
        pat_units_next = pat_units_reg;
        select_next    = select_reg;
        seg_next       = seg_reg;
        enables_next   = enables_reg;
        if (tick.slow)
        begin
            if (tick.any)
            begin
                pat_tens_next  = glyph(tens_clip(duty));
                pat_units_next = glyph(units_of(duty));
            end
            if (duty == 7'd0)
            begin
                enables_next = EnUnits;
                seg_next     = SegZero;
            end
            else if (duty == DutyMax)
            begin
                enables_next = EnBoth;
                seg_next     = SegFull;
            end
            else if (!select_reg)
            begin
                seg_next     = pat_tens_next;
                enables_next = EnTens;
                select_next  = 1'b1;
            end
            else
            begin
                seg_next     = pat_units_next;
                enables_next = EnUnits;
                select_next  = 1'b0;
            end
        end
    end

    // Hold display state between slow ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg    <= 1'b0;
            pat_tens_reg  <= PatTensReset;
            pat_units_reg <= PatUnitsReset;
            seg_reg       <= SegReset;
            enables_reg   <= EnBoth;
        end
        else
        begin
            select_reg    <= select_next;
            pat_tens_reg  <= pat_tens_next;
            pat_units_reg <= pat_units_next;
            seg_reg       <= seg_next;
            enables_reg   <= enables_next;
        end
    end

endmodule

// ===== sv/pwm_dimmer_button_adjust_core.sv =====
// A result is presented in the cycle after its input transfer, from the result register.
// Throughput: one item per clock while the receiver does not stall; the one-entry result
// register sets it, and an input is taken in the same cycle that a waiting result is taken.
// Reset (rst_n, asynchronous, active low): phase 0, duty 50, all counters 0, display with
// every segment lit and both digits on, bar all ones, level mask five bars, registers at
// their defaults.
`include "pwm_dimmer_button_adjust_core_assert.svh"

module pwm_dimmer_button_adjust_core
    import pdba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        down_pressed,
    input  logic        up_pressed,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pwm_level,
    output logic [9:0]  bar_leds,
    output logic [7:0]  seg_pattern,
    output logic        digit_one_on,
    output logic        digit_two_on,
    output logic [6:0]  duty_level,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers
    logic [7:0]  hold_delay_reg;
    logic [7:0]  repeat_ival_reg;
    logic [7:0]  flow_ival_reg;
    logic [7:0]  resync_ival_reg;

    // Block state
    logic [6:0]  phase_reg;
    logic [6:0]  phase_next;
    logic [6:0]  phase_inc;
    logic [6:0]  duty_reg;
    logic [6:0]  duty_next;
    logic [8:0]  hold_reg;
    logic [8:0]  hold_next;
    logic [8:0]  hold_step;
    logic [7:0]  repeat_reg;
    logic [7:0]  repeat_next;
    logic [7:0]  repeat_inc;
    logic [9:0]  level_reg;
    logic [9:0]  level_next;
    logic [10:0] flow_reg;
    logic [10:0] flow_next;
    logic [11:0] flow_shift;
    logic [11:0] flow_lim;
    logic [7:0]  flow_cnt_reg;
    logic [7:0]  flow_cnt_next;
    logic [7:0]  flow_cnt_inc;
    logic [7:0]  resync_cnt_reg;
    logic [7:0]  resync_cnt_next;
    logic [7:0]  resync_cnt_inc;
    logic [9:0]  bar_reg;
    logic [9:0]  bar_next;

    // Handshake and result register
    logic        accept;
    logic        any;
    logic        adjusting;
    tick_t       tick;
    logic [7:0]  seg_next;
    logic [1:0]  enables_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        pwm_out_reg;
    logic [9:0]  bar_out_reg;
    logic [7:0]  seg_out_reg;
    logic [1:0]  en_out_reg;
    logic [6:0]  duty_out_reg;

    // Step duty by one, saturating at both ends
    function automatic logic [6:0] nudge(input logic [6:0] d, input logic up);
        logic [6:0] r;
        r = d;
        if (up)
        begin
            if (d < DutyMax)
                r = d + 7'd1;
        end
        else if (d > 7'd0)
        begin
            r = d - 7'd1;
        end
        return r;
    endfunction

    // Take an input whenever the result register is free or being emptied
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign any       = down_pressed || up_pressed;
    assign adjusting = down_pressed != up_pressed;

    // Advance the phase and flag the slow tick on wrap
    always_comb
    begin
        phase_inc  = phase_reg + 7'd1;
        tick.any   = any;
        tick.slow  = accept && (phase_inc >= PhaseWrap);
        phase_next = phase_reg;
        if (accept)
            phase_next = (phase_inc >= PhaseWrap) ? 7'd0 : phase_inc;
    end

    // Duty adjust: one step on press, auto-repeat after the hold delay
    always_comb
    begin
        duty_next   = duty_reg;
        hold_next   = hold_reg;
        hold_step   = hold_reg;
        repeat_next = repeat_reg;
        repeat_inc  = repeat_reg + 8'd1;
        if (tick.slow)
        begin
            if (adjusting)
            begin
                if (hold_reg == 9'd0)
                    duty_next = nudge(duty_reg, up_pressed);
                if (hold_reg <= {1'b0, hold_delay_reg})
                    hold_step = hold_reg + 9'd1;
                hold_next = hold_step;
                if (hold_step > {1'b0, hold_delay_reg})
                begin
                    if (repeat_inc > repeat_ival_reg)
                    begin
                        repeat_next = 8'd0;
                        duty_next   = nudge(duty_next, up_pressed);
                    end
                    else
                    begin
                        repeat_next = repeat_inc;
                    end
                end
            end
            else if (!down_pressed)
            begin
                hold_next   = 9'd0;
                repeat_next = 8'd0;
            end
        end
    end

    // Bar flow advance and level-mask refresh
    always_comb
    begin
        flow_next       = flow_reg;
        bar_next        = bar_reg;
        level_next      = level_reg;
        flow_cnt_next   = flow_cnt_reg;
        resync_cnt_next = resync_cnt_reg;
        flow_cnt_inc    = flow_cnt_reg + 8'd1;
        resync_cnt_inc  = resync_cnt_reg + 8'd1;
        flow_shift      = {flow_reg, 1'b1};
        flow_lim        = {1'b0, level_reg, 1'b1};
        if (tick.slow)
        begin
            flow_cnt_next = flow_cnt_inc;
            if (flow_cnt_inc >= flow_ival_reg)
            begin
                flow_cnt_next = 8'd0;
                flow_next     = (flow_shift >= flow_lim) ? 11'd0 : flow_shift[10:0];
                bar_next      = flow_next[9:0] & level_reg;
            end
            resync_cnt_next = resync_cnt_inc;
            if (resync_cnt_inc >= resync_ival_reg)
            begin
                resync_cnt_next = 8'd0;
                if (any)
                    level_next = thermometer(duty_next);
            end
        end
    end

    pdba_display u_display (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .duty         (duty_reg),
        .seg_next     (seg_next),
        .enables_next (enables_next)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_delay_reg  <= HoldDelayReset;
            repeat_ival_reg <= RepeatIvalReset;
            flow_ival_reg   <= FlowIvalReset;
            resync_ival_reg <= ResyncIvalReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_HOLD_DELAY:      hold_delay_reg  <= cfg_data;
                CFG_REPEAT_INTERVAL: repeat_ival_reg <= cfg_data;
                CFG_FLOW_INTERVAL:   flow_ival_reg   <= cfg_data;
                CFG_RESYNC_INTERVAL: resync_ival_reg <= cfg_data;
                default:             hold_delay_reg  <= hold_delay_reg;
            endcase
        end
    end

    // Hold block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 7'd0;
            duty_reg       <= DutyReset;
            hold_reg       <= 9'd0;
            repeat_reg     <= 8'd0;
            level_reg      <= LevelReset;
            flow_reg       <= 11'd0;
            flow_cnt_reg   <= 8'd0;
            resync_cnt_reg <= 8'd0;
            bar_reg        <= BarReset;
        end
        else
        begin
            phase_reg      <= phase_next;
            duty_reg       <= duty_next;
            hold_reg       <= hold_next;
            repeat_reg     <= repeat_next;
            level_reg      <= level_next;
            flow_reg       <= flow_next;
            flow_cnt_reg   <= flow_cnt_next;
            resync_cnt_reg <= resync_cnt_next;
            bar_reg        <= bar_next;
        end
    end

    // Result valid: set on transfer in, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load the result payload on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pwm_out_reg  <= (phase_reg >= duty_reg);
            bar_out_reg  <= bar_next;
            seg_out_reg  <= seg_next;
            en_out_reg   <= enables_next;
            duty_out_reg <= duty_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pwm_level    = pwm_out_reg;
    assign bar_leds     = bar_out_reg;
    assign seg_pattern  = seg_out_reg;
    assign digit_one_on = en_out_reg[0];
    assign digit_two_on = en_out_reg[1];
    assign duty_level   = duty_out_reg;

    `PDBA_ASSERT_NOW(a_duty_range, 1'b1, duty_reg <= DutyMax, "duty beyond full scale")
    `PDBA_ASSERT_NOW(a_phase_range, 1'b1, phase_reg < PhaseWrap, "phase beyond wrap point")
    `PDBA_ASSERT_NEXT(a_duty_slow_only, accept && (phase_inc < PhaseWrap),
        $stable(duty_reg), "duty moved off a slow tick")
    `PDBA_ASSERT_NEXT(a_result_loaded, accept, out_valid_reg, "accepted item left no result")

endmodule

// ===== dv/tb_pwm_dimmer_button_adjust_core.sv =====
`timescale 1ns / 1ps

module tb_pwm_dimmer_button_adjust_core;
    import pdba_pkg::*;

    // One button sample per base PWM tick
    typedef struct packed {
        logic down;
        logic up;
    } press_t;

    // One sampled set of output pins
    typedef struct packed {
        logic       pwm;
        logic [9:0] bar;
        logic [7:0] seg;
        logic       dig1;
        logic       dig2;
        logic [6:0] duty;
    } dimmer_out_t;

    typedef enum logic [2:0] {
        BTN_NONE,
        BTN_UP,
        BTN_DOWN,
        BTN_BOTH,
        BTN_NOISE
    } gesture_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       down_pressed = 1'b0;
    logic       up_pressed = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       pwm_level;
    logic [9:0] bar_leds;
    logic [7:0] seg_pattern;
    logic       digit_one_on;
    logic       digit_two_on;
    logic [6:0] duty_level;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    pwm_dimmer_button_adjust_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .down_pressed (down_pressed),
        .up_pressed   (up_pressed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pwm_level    (pwm_level),
        .bar_leds     (bar_leds),
        .seg_pattern  (seg_pattern),
        .digit_one_on (digit_one_on),
        .digit_two_on (digit_two_on),
        .duty_level   (duty_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Glyphs for digits 0..9; ten has none and blanks the digit
    logic [7:0] seg_glyph [0:10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D,
                                     8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h00};

    // Dimmer state mirrored by the predictor
    logic [7:0]  m_hold_delay;
    logic [7:0]  m_repeat_ival;
    logic [7:0]  m_flow_ival;
    logic [7:0]  m_resync_ival;
    logic [6:0]  m_phase;
    logic [6:0]  m_duty;
    logic [8:0]  m_hold_cnt;
    logic [7:0]  m_repeat_cnt;
    logic        m_digit_sel;
    logic [7:0]  m_pattern [0:1];
    logic [9:0]  m_level_mask;
    logic [10:0] m_flow_mask;
    logic [7:0]  m_flow_cnt;
    logic [7:0]  m_resync_cnt;
    logic [7:0]  m_seg;
    logic [1:0]  m_enables;
    logic [9:0]  m_bar;

    press_t      presses_pending [$];
    dimmer_out_t expected_frames [$];
    press_t      next_press;
    dimmer_out_t front_frame;

    int unsigned queued_total = 0;
    int unsigned accepted = 0;
    int unsigned checked = 0;
    int unsigned mismatches = 0;
    int unsigned slow_ticks = 0;
    int unsigned repeat_steps = 0;
    int unsigned reg_writes = 0;
    int unsigned duty_lo = 100;
    int unsigned duty_hi = 0;
    int unsigned gap_left = 0;
    int unsigned calm_left = 0;
    int unsigned stall_left = 0;
    int unsigned free_left = 0;
    int unsigned stall_roll;
    logic        hold_off_pending = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic reset_model();
        m_hold_delay  = HoldDelayReset;
        m_repeat_ival = RepeatIvalReset;
        m_flow_ival   = FlowIvalReset;
        m_resync_ival = ResyncIvalReset;
        m_phase       = '0;
        m_duty        = DutyReset;
        m_hold_cnt    = '0;
        m_repeat_cnt  = '0;
        m_digit_sel   = 1'b0;
        m_pattern[0]  = PatTensReset;
        m_pattern[1]  = PatUnitsReset;
        m_level_mask  = LevelReset;
        m_flow_mask   = '0;
        m_flow_cnt    = '0;
        m_resync_cnt  = '0;
        m_seg         = SegReset;
        m_enables     = EnBoth;
        m_bar         = BarReset;
    endtask

    // Step duty by one, saturating at both ends
    function automatic void nudge_duty(input logic upward);
        if (upward) begin
            if (m_duty < DutyMax)
                m_duty = m_duty + 7'd1;
        end
        else if (m_duty > 7'd0) begin
            m_duty = m_duty - 7'd1;
        end
    endfunction

    // Advance the dimmer by one base tick and return the pins after it
    function automatic dimmer_out_t dimmer_tick(input logic dn, input logic upb);
        dimmer_out_t r;
        logic        any;
        logic [11:0] flow_next;
        logic [11:0] flow_lim;
        logic [10:0] fill;
        any = dn | upb;
        r.pwm = (m_phase < m_duty) ? 1'b0 : 1'b1;
        m_phase = m_phase + 7'd1;
        if (m_phase >= PhaseWrap) begin
            m_phase = '0;
            slow_ticks++;

            // Multiplex the display from the duty held before this tick
            if (any) begin
                m_pattern[0] = seg_glyph[m_duty / 10];
                m_pattern[1] = seg_glyph[m_duty % 10];
            end
            if (m_duty == 7'd0) begin
                m_enables = EnUnits;
                m_seg     = SegZero;
            end
            else if (m_duty == DutyMax) begin
                m_enables = EnBoth;
                m_seg     = SegFull;
            end
            else if (!m_digit_sel) begin
                m_seg       = m_pattern[0];
                m_enables   = EnTens;
                m_digit_sel = 1'b1;
            end
            else begin
                m_seg       = m_pattern[1];
                m_enables   = EnUnits;
                m_digit_sel = 1'b0;
            end

            // Single step on press, then auto-repeat once the hold delay runs out
            if (dn != upb) begin
                if (m_hold_cnt == 9'd0)
                    nudge_duty(upb);
                if (m_hold_cnt <= {1'b0, m_hold_delay})
                    m_hold_cnt = m_hold_cnt + 9'd1;
                if (m_hold_cnt > {1'b0, m_hold_delay}) begin
                    m_repeat_cnt = m_repeat_cnt + 8'd1;
                    if (m_repeat_cnt > m_repeat_ival) begin
                        m_repeat_cnt = '0;
                        nudge_duty(upb);
                        repeat_steps++;
                    end
                end
            end
            else if (!dn) begin
                m_hold_cnt   = '0;
                m_repeat_cnt = '0;
            end

            // Advance the flowing bar, restarting once it passes the level
            m_flow_cnt = m_flow_cnt + 8'd1;
            if (m_flow_cnt >= m_flow_ival) begin
                m_flow_cnt = '0;
                flow_next = {m_flow_mask, 1'b1};
                flow_lim  = {1'b0, m_level_mask, 1'b1};
                if (flow_next >= flow_lim)
                    flow_next = '0;
                m_flow_mask = flow_next[10:0];
                m_bar = m_flow_mask[9:0] & m_level_mask;
            end

            // Refresh the level mask from the duty while a button is held
            m_resync_cnt = m_resync_cnt + 8'd1;
            if (m_resync_cnt >= m_resync_ival) begin
                m_resync_cnt = '0;
                if (any) begin
                    fill = (11'd1 << (m_duty / 10)) - 11'd1;
                    m_level_mask = fill[9:0];
                end
            end

            if (32'(m_duty) < duty_lo)
                duty_lo = 32'(m_duty);
            if (32'(m_duty) > duty_hi)
                duty_hi = 32'(m_duty);
        end
        r.bar  = m_bar;
        r.seg  = m_seg;
        r.dig1 = m_enables[0];
        r.dig2 = m_enables[1];
        r.duty = m_duty;
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones, now and then a calm run
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (roll < 3) begin
            calm_left = $urandom_range(50, 200);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: offer queued presses, hold while stalled, predict on each transfer
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid     <= 1'b0;
            down_pressed <= 1'b0;
            up_pressed   <= 1'b0;
            gap_left = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                expected_frames.push_back(dimmer_tick(down_pressed, up_pressed));
                accepted++;
            end
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (presses_pending.size() != 0) begin
                    next_press = presses_pending.pop_front();
                    in_valid     <= 1'b1;
                    down_pressed <= next_press.down;
                    up_pressed   <= next_press.up;
                    gap_left = pick_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer and drive the receiver stall
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    mismatches++;
                end
                else begin
                    front_frame = expected_frames.pop_front();
                    check_field("pwm_level", 32'(front_frame.pwm), 32'(pwm_level));
                    check_field("bar_leds", 32'(front_frame.bar), 32'(bar_leds));
                    check_field("seg_pattern", 32'(front_frame.seg), 32'(seg_pattern));
                    check_field("digit_one_on", 32'(front_frame.dig1), 32'(digit_one_on));
                    check_field("digit_two_on", 32'(front_frame.dig2), 32'(digit_two_on));
                    check_field("duty_level", 32'(front_frame.duty), 32'(duty_level));
                end
                checked++;
            end

            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                free_left  = 0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0) begin
                free_left--;
                out_stall <= 1'b0;
            end
            else begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 45) begin
                    free_left = $urandom_range(0, 6);
                    out_stall <= 1'b0;
                end
                else if (stall_roll < 50) begin
                    free_left = $urandom_range(80, 300);
                    out_stall <= 1'b0;
                end
                else if (stall_roll < 93) begin
                    stall_left = $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end
                else begin
                    stall_left = $urandom_range(10, 50);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    task automatic push_press(input logic dn, input logic upb);
        press_t p;
        p.down = dn;
        p.up   = upb;
        presses_pending.push_back(p);
        queued_total++;
    endtask

    // Hold one button pattern for len ticks, with the odd stray sample
    task automatic push_gesture(input gesture_t kind, input int unsigned len);
        logic dn;
        logic upb;
        for (int unsigned i = 0; i < len; i++) begin
            dn  = (kind == BTN_DOWN) || (kind == BTN_BOTH);
            upb = (kind == BTN_UP) || (kind == BTN_BOTH);
            if (kind == BTN_NOISE || $urandom_range(0, 63) == 0) begin
                dn  = 1'($urandom_range(0, 1));
                upb = 1'($urandom_range(0, 1));
            end
            push_press(dn, upb);
        end
    endtask

    // Random button gestures, mostly a few slow ticks long, some much longer
    task automatic push_random(input int unsigned count);
        int unsigned added;
        int unsigned roll;
        int unsigned ticks;
        int unsigned len;
        gesture_t    kind;
        added = 0;
        while (added < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                kind = BTN_UP;
            else if (roll < 60)
                kind = BTN_DOWN;
            else if (roll < 80)
                kind = BTN_NONE;
            else if (roll < 90)
                kind = BTN_BOTH;
            else
                kind = BTN_NOISE;
            ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
            len = ticks * 100 + $urandom_range(0, 99) - 50;
            // Trim the last gesture so the batch stays at its size
            if (len > count - added)
                len = count - added;
            push_gesture(kind, len);
            added += len;
        end
    endtask

    task automatic wait_drain();
        while (checked < queued_total)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HOLD_DELAY:      m_hold_delay  = value;
            CFG_REPEAT_INTERVAL: m_repeat_ival = value;
            CFG_FLOW_INTERVAL:   m_flow_ival   = value;
            CFG_RESYNC_INTERVAL: m_resync_ival = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [7:0] hold, input logic [7:0] rpt,
                                  input logic [7:0] flow, input logic [7:0] resync);
        write_reg(CFG_HOLD_DELAY, hold);
        write_reg(CFG_REPEAT_INTERVAL, rpt);
        write_reg(CFG_FLOW_INTERVAL, flow);
        write_reg(CFG_RESYNC_INTERVAL, resync);
    endtask

    // Mostly small values so repeats and refreshes come quickly
    function automatic logic [7:0] pick_setting();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 8'($urandom_range(1, 6));
        if (roll < 85)
            return 8'($urandom_range(0, 255));
        if (roll < 90)
            return 8'd0;
        if (roll < 95)
            return 8'd1;
        return 8'd255;
    endfunction

    initial begin
        int unsigned mark;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: every button combination, at reset settings
        for (int i = 0; i < 24; i++)
            push_press(i[0] ^ i[2], i[1]);
        push_random(150);
        wait_drain();

        // Zero intervals: hold down, then up, then both, then down again
        apply_settings(8'd0, 8'd0, 8'd0, 8'd0);
        push_gesture(BTN_DOWN, 120);
        push_gesture(BTN_UP, 120);
        push_gesture(BTN_BOTH, 30);
        push_gesture(BTN_DOWN, 30);
        push_random(50);
        wait_drain();

        // Widest intervals; let the receiver hold off long so the input backs up
        apply_settings(8'd255, 8'd255, 8'd255, 8'd255);
        push_random(150);
        mark = accepted;
        while (accepted < mark + 100)
            @(posedge clk);
        hold_off_pending = 1'b1;
        wait_drain();

        // Immediate repeat armed but the repeat counter never passes its limit
        apply_settings(8'd1, 8'd255, 8'd1, 8'd1);
        push_random(100);
        wait_drain();

        for (int k = 0; k < 4; k++) begin
            apply_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting());
            push_random(60);
            wait_drain();
        end

        repeat (10) @(posedge clk);
        $display("summary: %0d results checked over %0d slow ticks, duty spanned %0d..%0d",
                 checked, slow_ticks, duty_lo, duty_hi);
        $display("summary: %0d auto-repeat steps, %0d register writes, %0d mismatches",
                 repeat_steps, reg_writes, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== pwm_dimmer_button_adjust_core.f =====
+incdir+sv
sv/pdba_pkg.sv
sv/pdba_display.sv
sv/pwm_dimmer_button_adjust_core.sv
dv/tb_pwm_dimmer_button_adjust_core.sv
